/* hdl/pipeline_execute_stage_alu_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the execute stage
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PIPELINE_EXECUTE_STAGE_ALU_TOP_ASSERT_SVH
`define PIPELINE_EXECUTE_STAGE_ALU_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PESA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PESA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/exalu_pkg.sv */
// ----------------------------------------------------------------------------
// exalu_pkg
// Types and codes shared by the Y86-64 execute stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package exalu_pkg;

   localparam int DATA_WIDTH_DEFAULT = 64;
   localparam int STACK_STEP         = 8;

   // instruction codes
   localparam logic [3:0] ICODE_HALT   = 4'd0;
   localparam logic [3:0] ICODE_NOP    = 4'd1;
   localparam logic [3:0] ICODE_RRMOVQ = 4'd2;
   localparam logic [3:0] ICODE_IRMOVQ = 4'd3;
   localparam logic [3:0] ICODE_RMMOVQ = 4'd4;
   localparam logic [3:0] ICODE_MRMOVQ = 4'd5;
   localparam logic [3:0] ICODE_OPQ    = 4'd6;
   localparam logic [3:0] ICODE_JXX    = 4'd7;
   localparam logic [3:0] ICODE_CALL   = 4'd8;
   localparam logic [3:0] ICODE_RET    = 4'd9;
   localparam logic [3:0] ICODE_PUSHQ  = 4'd10;
   localparam logic [3:0] ICODE_POPQ   = 4'd11;

   // ALU functions
   localparam logic [3:0] ALU_ADD = 4'd0;
   localparam logic [3:0] ALU_SUB = 4'd1;
   localparam logic [3:0] ALU_AND = 4'd2;
   localparam logic [3:0] ALU_XOR = 4'd3;

   // condition selectors
   localparam logic [3:0] COND_ALWAYS = 4'd0;
   localparam logic [3:0] COND_LE     = 4'd1;
   localparam logic [3:0] COND_L      = 4'd2;
   localparam logic [3:0] COND_E      = 4'd3;
   localparam logic [3:0] COND_NE     = 4'd4;
   localparam logic [3:0] COND_GE     = 4'd5;
   localparam logic [3:0] COND_G      = 4'd6;

   // status codes
   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_ADR = 2'd1;
   localparam logic [1:0] STAT_INS = 2'd2;
   localparam logic [1:0] STAT_HLT = 2'd3;

   // condition flag bits
   localparam int         FLAG_ZF     = 0;
   localparam int         FLAG_SF     = 1;
   localparam int         FLAG_OF     = 2;
   localparam logic [2:0] FLAGS_RESET = 3'b001;

   localparam logic [3:0] REG_NONE = 4'hF;

   typedef struct packed {
      logic [1:0]  instr_status;
      logic [3:0]  instr_code;
      logic [3:0]  instr_function;
      logic [63:0] constant_value;
      logic [63:0] operand_a_value;
      logic [63:0] operand_b_value;
      logic [3:0]  dest_e_reg;
      logic [3:0]  dest_m_reg;
      logic [1:0]  mem_stage_status;
      logic [1:0]  wb_stage_status;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_status;
      logic [3:0]  out_code;
      logic        cond_taken;
      logic [63:0] alu_result;
      logic [63:0] passed_a_value;
      logic [3:0]  result_dest_e;
      logic [3:0]  result_dest_m;
      logic        bubble_memory;
   } rsp_type;

endpackage

/* hdl/pipeline_execute_stage_alu_top.sv */
// Y86-64 execute stage.
// Input channel req_*: one instruction's execute-register fields plus the
// statuses now held in the memory and writeback stages, as one transaction.
// Result channel rsp_*: the memory register inputs (status, code, condition,
// valE, valA, destinations) and the bubble request for the memory stage.
// Path: a transaction is held in the input register, then in the result
// register, which drives rsp_valid. Throughput: one transaction per cycle
// while rsp_ready is high; the input register feeds the ALU, flag and
// condition logic, which is written into the result register. The condition
// flags are updated as an OPq instruction leaves the input register, unless
// a later stage holds an exception; the next instruction sees them at once.
// Reset: both registers empty, zero flag set, sign and overflow clear.
// Stall: while rsp_ready is low the result holds; the input register still
// takes one more transaction, then req_ready drops until the result is taken.
// ----------------------------------------------------------------------------
// pipeline_execute_stage_alu_top
// Execute stage: operand select, ALU, condition flags and condition check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipeline_execute_stage_alu_top
   import exalu_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [DATA_WIDTH-1:0] STEP_POS = DATA_WIDTH'(STACK_STEP);
   localparam logic [DATA_WIDTH-1:0] STEP_NEG = DATA_WIDTH'(0) - STEP_POS;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [1:0]            s1_status_ff;
   logic [3:0]            s1_code_ff;
   logic [3:0]            s1_func_ff;
   logic [DATA_WIDTH-1:0] s1_valc_ff;
   logic [DATA_WIDTH-1:0] s1_vala_ff;
   logic [DATA_WIDTH-1:0] s1_valb_ff;
   logic [3:0]            s1_dste_ff;
   logic [3:0]            s1_dstm_ff;
   logic                  s1_later_exc_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [1:0]            out_status_ff;
   logic [3:0]            out_code_ff;
   logic                  out_cnd_ff;
   logic [DATA_WIDTH-1:0] out_vale_ff;
   logic [DATA_WIDTH-1:0] out_vala_ff;
   logic [3:0]            out_dste_ff;
   logic [3:0]            out_dstm_ff;
   logic                  out_bubble_ff;

   logic [2:0]            flags_ff, flags_in;

   logic                  out_free;
   logic                  s1_adv;
   logic                  s1_load;

   logic [DATA_WIDTH-1:0] alu_a;
   logic [DATA_WIDTH-1:0] alu_b;
   logic [3:0]            alu_fn;
   logic [DATA_WIDTH-1:0] alu_res;
   logic                  alu_ovf;
   logic                  lt;
   logic                  cnd;
   logic                  cond_op;
   logic [3:0]            dste;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign s1_load   = req_valid && req_ready;

   // operand select
   always_comb begin
      unique case (s1_code_ff)
         ICODE_RRMOVQ, ICODE_OPQ:                  alu_a = s1_vala_ff;
         ICODE_IRMOVQ, ICODE_RMMOVQ, ICODE_MRMOVQ: alu_a = s1_valc_ff;
         ICODE_CALL, ICODE_PUSHQ:                  alu_a = STEP_NEG;
         ICODE_RET, ICODE_POPQ:                    alu_a = STEP_POS;
         default:                                  alu_a = '0;
      endcase
      unique case (s1_code_ff)
         ICODE_RMMOVQ, ICODE_MRMOVQ, ICODE_OPQ, ICODE_CALL,
         ICODE_RET, ICODE_PUSHQ, ICODE_POPQ:       alu_b = s1_valb_ff;
         default:                                  alu_b = '0;
      endcase
      alu_fn = (s1_code_ff == ICODE_OPQ) ? s1_func_ff : ALU_ADD;
   end

   // ALU
   always_comb begin
      alu_ovf = 1'b0;
      unique case (alu_fn)
         ALU_ADD: begin
            alu_res = alu_a + alu_b;
            alu_ovf = (alu_a[DATA_WIDTH-1] == alu_b[DATA_WIDTH-1])
                      && (alu_res[DATA_WIDTH-1] != alu_a[DATA_WIDTH-1]);
         end
         ALU_SUB: begin
            alu_res = alu_b - alu_a;
            alu_ovf = (alu_a[DATA_WIDTH-1] != alu_b[DATA_WIDTH-1])
                      && (alu_res[DATA_WIDTH-1] != alu_b[DATA_WIDTH-1]);
         end
         ALU_AND: alu_res = alu_a & alu_b;
         ALU_XOR: alu_res = alu_a ^ alu_b;
         default: alu_res = '0;
      endcase
   end

   // condition check against the flags left by earlier instructions
   always_comb begin
      lt      = flags_ff[FLAG_SF] ^ flags_ff[FLAG_OF];
      cond_op = (s1_code_ff == ICODE_RRMOVQ) || (s1_code_ff == ICODE_JXX);
      unique case (s1_func_ff)
         COND_ALWAYS: cnd = 1'b1;
         COND_LE:     cnd = lt | flags_ff[FLAG_ZF];
         COND_L:      cnd = lt;
         COND_E:      cnd = flags_ff[FLAG_ZF];
         COND_NE:     cnd = !flags_ff[FLAG_ZF];
         COND_GE:     cnd = !lt;
         COND_G:      cnd = !lt && !flags_ff[FLAG_ZF];
         default:     cnd = 1'b0;
      endcase
      cnd  = cnd && cond_op;
      // cancel the destination of a move whose condition fails
      dste = ((s1_code_ff == ICODE_RRMOVQ) && !cnd) ? REG_NONE : s1_dste_ff;
   end

   always_comb begin
      flags_in = flags_ff;
      if (s1_adv && (s1_code_ff == ICODE_OPQ) && !s1_later_exc_ff) begin
         flags_in[FLAG_ZF] = (alu_res == '0);
         flags_in[FLAG_SF] = alu_res[DATA_WIDTH-1];
         flags_in[FLAG_OF] = alu_ovf;
      end
   end

   assign s1_valid_in  = s1_load || (s1_valid_ff && !out_free);
   assign out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= FLAGS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_status_ff    <= req_data.instr_status;
         s1_code_ff      <= req_data.instr_code;
         s1_func_ff      <= req_data.instr_function;
         s1_valc_ff      <= req_data.constant_value[DATA_WIDTH-1:0];
         s1_vala_ff      <= req_data.operand_a_value[DATA_WIDTH-1:0];
         s1_valb_ff      <= req_data.operand_b_value[DATA_WIDTH-1:0];
         s1_dste_ff      <= req_data.dest_e_reg;
         s1_dstm_ff      <= req_data.dest_m_reg;
         s1_later_exc_ff <= (req_data.mem_stage_status != STAT_OK)
                            || (req_data.wb_stage_status != STAT_OK);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_status_ff <= s1_status_ff;
         out_code_ff   <= s1_code_ff;
         out_cnd_ff    <= cnd;
         out_vale_ff   <= alu_res;
         out_vala_ff   <= s1_vala_ff;
         out_dste_ff   <= dste;
         out_dstm_ff   <= s1_dstm_ff;
         out_bubble_ff <= s1_later_exc_ff;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_data.out_status     = out_status_ff;
   assign rsp_data.out_code       = out_code_ff;
   assign rsp_data.cond_taken     = out_cnd_ff;
   assign rsp_data.alu_result     = 64'(out_vale_ff);
   assign rsp_data.passed_a_value = 64'(out_vala_ff);
   assign rsp_data.result_dest_e  = out_dste_ff;
   assign rsp_data.result_dest_m  = out_dstm_ff;
   assign rsp_data.bubble_memory  = out_bubble_ff;

`include "pipeline_execute_stage_alu_top_assert.svh"

   `PESA_ASSERT_SAME(a_flags_after_reset, $past(reset), flags_ff == FLAGS_RESET,
      "flags not at reset value after reset")
   `PESA_ASSERT_NEXT(a_flags_kept_on_exc, s1_adv && s1_later_exc_ff, $stable(flags_ff),
      "flags changed while a later stage held an exception")
   `PESA_ASSERT_NEXT(a_flags_kept_non_op,
      !(s1_adv && (s1_code_ff == ICODE_OPQ)), $stable(flags_ff),
      "flags changed without an OPq transaction")
   `PESA_ASSERT_SAME(a_cmov_cancel,
      out_valid_ff && (out_code_ff == ICODE_RRMOVQ) && !out_cnd_ff,
      out_dste_ff == REG_NONE, "failed conditional move kept its destination")
   `PESA_ASSERT_SAME(a_cond_only_branch_move, out_valid_ff && out_cnd_ff,
      (out_code_ff == ICODE_RRMOVQ) || (out_code_ff == ICODE_JXX),
      "condition set for an instruction that has none")

endmodule
